// ===== src/smbd_pkg.sv =====
// Package with constants, request codes and sequencer states of the bounded SplitMix64 draw.
`timescale 1ns / 1ps

package smbd_pkg;

    // SplitMix64 increment and mixing constants.
    localparam logic [63:0] GOLDEN_GAMMA = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [63:0] MIX_MUL_A    = 64'hBF58_476D_1CE4_E5B9;
    localparam logic [63:0] MIX_MUL_B    = 64'h94D0_49BB_1331_11EB;
    localparam int unsigned SHIFT_1      = 30;
    localparam int unsigned SHIFT_2      = 27;
    localparam int unsigned SHIFT_3      = 31;

    // Flips the sign bit so that signed bounds compare as unsigned values.
    localparam logic [31:0] SIGN_BIAS = 32'h8000_0000;

    // Request codes carried in req_type.
    typedef enum logic [1:0] {
        REQ_RESTART = 2'd0,
        REQ_RAW     = 2'd1,
        REQ_BOUNDED = 2'd2
    } t_req;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_ADD,
        S_MIX,
        S_MUL,
        S_CHECK,
        S_WB
    } t_state;

endpackage

// ===== src/smbd_if.sv =====
// Channel interfaces of the bounded SplitMix64 draw: request, result and seed write.
`timescale 1ns / 1ps

interface smbd_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         req_type;
    logic signed [31:0] range_min;
    logic signed [31:0] range_max;

    modport source (output valid, output req_type, output range_min, output range_max,
                    input ready);
    modport sink   (input valid, input req_type, input range_min, input range_max,
                    output ready);
endinterface

interface smbd_res_if;
    logic               valid;
    logic               ready;
    logic [63:0]        raw_value;
    logic signed [31:0] bounded_value;
    logic [63:0]        draws_used;
    logic               range_error;

    modport source (output valid, output raw_value, output bounded_value,
                    output draws_used, output range_error, input ready);
    modport sink   (input valid, input raw_value, input bounded_value,
                    input draws_used, input range_error, output ready);
endinterface

interface smbd_cfg_if;
    logic        valid;
    logic        ready;
    logic [63:0] seed_state;

    modport source (output valid, output seed_state, input ready);
    modport sink   (input valid, input seed_state, output ready);
endinterface

// ===== src/splitmix64_bounded_draw.sv =====
// Top level: SplitMix64 generator with unbiased bounded draws on one shared datapath.
// Restart, inverted bounds and unused codes go from S_IDLE straight to S_WB and the output register.
// A raw draw passes the accepting state, one add, two xor-shift/multiply rounds of one xor-shift
// step and three partial-product steps each, one check and one write-back.
// A bounded draw adds a division for the rejection threshold, an add/mix/check pass per redraw and
// a division for the final remainder, both on the one-bit-per-cycle restoring divider.
// One request is worked at a time; the next is taken once the result sits in the output register.
// Reset clears the seed register, generator state, draw counter and all handshake state.
`timescale 1ns / 1ps

module splitmix64_bounded_draw
    import smbd_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    smbd_cfg_if.sink        i_cfg,
    smbd_req_if.sink        i_req,
    smbd_res_if.source      o_res
);

    // Architectural state.
    logic [63:0] r_seed;
    logic [63:0] r_gen;
    logic [63:0] r_draws;

    // Sequencer.
    t_state r_state;
    t_state n_state;

    // Working registers.
    logic [63:0] r_z;
    logic [63:0] r_acc;
    logic [1:0]  r_k;
    logic        r_phase;
    logic        r_bounded_req;
    logic [32:0] r_range;
    logic [32:0] r_thr;
    logic        r_thr_mode;
    logic [63:0] r_dq;
    logic [32:0] r_rem;
    logic [5:0]  r_bit;
    logic [31:0] r_lo;

    // Pending result.
    logic [63:0] r_raw;
    logic [31:0] r_bnd;
    logic        r_err;

    // Output register.
    logic               r_out_valid;
    logic [63:0]        r_out_raw;
    logic signed [31:0] r_out_bnd;
    logic [63:0]        r_out_draws;
    logic               r_out_err;

    // Control.
    logic req_beat;
    logic wb_go;
    logic idle_ready;

    // Request decode.
    logic [31:0] lo_b;
    logic [31:0] hi_b;
    logic        bad_bounds;
    logic [32:0] range_w;
    t_req        req_code;

    // Shared datapath pieces.
    logic [63:0] gen_next;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] mul_p;
    logic [63:0] const_sel;
    logic [63:0] z_fin;
    logic [33:0] div_t;
    logic        div_ge;
    logic [32:0] rem_next;

    assign req_code   = t_req'(i_req.req_type);
    assign lo_b       = i_req.range_min ^ SIGN_BIAS;
    assign hi_b       = i_req.range_max ^ SIGN_BIAS;
    assign bad_bounds = lo_b > hi_b;
    assign range_w    = {1'b0, hi_b} - {1'b0, lo_b} + 33'd1;

    // Golden-gamma step of the generator state.
    assign gen_next = r_gen + GOLDEN_GAMMA;

    // Shared 32x32 multiplier: low 64 bits of a 64x64 product in three partial products.
    assign const_sel = r_phase ? MIX_MUL_B : MIX_MUL_A;
    always_comb begin
        case (r_k)
            2'd0: begin
                mul_a = r_z[31:0];
                mul_b = const_sel[31:0];
            end
            2'd1: begin
                mul_a = r_z[31:0];
                mul_b = const_sel[63:32];
            end
            default: begin
                mul_a = r_z[63:32];
                mul_b = const_sel[31:0];
            end
        endcase
    end
    assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

    // Final xor-shift of the mixed value.
    assign z_fin = r_z ^ (r_z >> SHIFT_3);

    // Restoring divider step: one dividend bit per cycle, remainder only.
    assign div_t    = {r_rem, r_dq[63]};
    assign div_ge   = div_t >= {1'b0, r_range};
    assign rem_next = div_ge ? 33'(div_t - {1'b0, r_range}) : div_t[32:0];

    // Output register takes a result when it is empty or being drained.
    assign wb_go = !r_out_valid || o_res.ready;

    // Handshake outputs of the sequencer.
    always_comb begin
        idle_ready = 1'b0;
        case (r_state)
            S_IDLE:  idle_ready = 1'b1;
            default: idle_ready = 1'b0;
        endcase
    end
    assign i_req.ready = idle_ready;
    assign i_cfg.ready = 1'b1;
    assign req_beat    = i_req.valid && idle_ready;

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (req_beat) begin
                    case (req_code)
                        REQ_RAW:     n_state = S_ADD;
                        REQ_BOUNDED: n_state = bad_bounds ? S_WB : S_DIV;
                        default:     n_state = S_WB;
                    endcase
                end
            end
            S_DIV: begin
                if (r_bit == 6'd63) begin
                    n_state = r_thr_mode ? S_ADD : S_WB;
                end
            end
            S_ADD:   n_state = S_MIX;
            S_MIX:   n_state = S_MUL;
            S_MUL: begin
                if (r_k == 2'd2) begin
                    n_state = r_phase ? S_CHECK : S_MIX;
                end
            end
            S_CHECK: begin
                if (!r_bounded_req) begin
                    n_state = S_WB;
                end else if ({31'd0, r_thr} > z_fin) begin
                    n_state = S_ADD;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_WB: begin
                if (wb_go) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Sequencer state and architectural state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_seed  <= 64'd0;
            r_gen   <= 64'd0;
            r_draws <= 64'd0;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid) begin
                r_seed <= i_cfg.seed_state;
            end
            if (req_beat && req_code == REQ_RESTART) begin
                r_gen   <= r_seed;
                r_draws <= 64'd0;
            end
            if (r_state == S_ADD) begin
                r_gen   <= gen_next;
                r_draws <= r_draws + 64'd1;
            end
        end
    end

    // Datapath registers driven by the sequencer.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                // Decode a request beat and clear the pending result.
                r_raw         <= 64'd0;
                r_bnd         <= 32'd0;
                r_err         <= req_beat && req_code == REQ_BOUNDED && bad_bounds;
                r_bounded_req <= req_beat && req_code == REQ_BOUNDED;
                r_lo          <= i_req.range_min;
                r_range       <= range_w;
                r_dq          <= 64'd0 - {31'd0, range_w};
                r_rem         <= 33'd0;
                r_bit         <= 6'd0;
                r_thr_mode    <= 1'b1;
            end
            S_DIV: begin
                r_dq  <= r_dq << 1;
                r_rem <= rem_next;
                r_bit <= r_bit + 6'd1;
                if (r_bit == 6'd63) begin
                    if (r_thr_mode) begin
                        r_thr <= rem_next;
                    end else begin
                        r_bnd <= r_lo + rem_next[31:0];
                    end
                end
            end
            S_ADD: begin
                r_z     <= gen_next;
                r_phase <= 1'b0;
            end
            S_MIX: begin
                r_z <= r_phase ? (r_z ^ (r_z >> SHIFT_2)) : (r_z ^ (r_z >> SHIFT_1));
                r_k <= 2'd0;
            end
            S_MUL: begin
                r_k <= r_k + 2'd1;
                if (r_k == 2'd0) begin
                    r_acc <= mul_p;
                end else if (r_k == 2'd1) begin
                    r_acc <= r_acc + {mul_p[31:0], 32'd0};
                end else begin
                    r_z     <= r_acc + {mul_p[31:0], 32'd0};
                    r_phase <= 1'b1;
                end
            end
            S_CHECK: begin
                // Keep the sample and set up its remainder by the range.
                r_raw      <= z_fin;
                r_dq       <= z_fin;
                r_rem      <= 33'd0;
                r_bit      <= 6'd0;
                r_thr_mode <= 1'b0;
            end
            default: begin
                r_raw <= r_raw;
            end
        endcase
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_WB && wb_go) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_WB && wb_go) begin
            r_out_raw   <= r_raw;
            r_out_bnd   <= r_bnd;
            r_out_draws <= r_draws;
            r_out_err   <= r_err;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.raw_value     = r_out_raw;
    assign o_res.bounded_value = r_out_bnd;
    assign o_res.draws_used    = r_out_draws;
    assign o_res.range_error   = r_out_err;

    // The draw counter only steps by one, clears on restart or holds.
    a_draw_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_draws != $past(r_draws) |-> r_draws == $past(r_draws) + 64'd1 || r_draws == 64'd0)
        else $error("draw counter moved by other than one step");

    // The divider remainder stays below the range.
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV |-> r_rem < r_range)
        else $error("divider remainder reached the range");

    // An inverted-bounds result carries no sample.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.range_error |-> o_res.raw_value == 64'd0 &&
        o_res.bounded_value == 32'sd0)
        else $error("range error result carries a sample");

endmodule
